/* rtl/core/rtdt_pkg.sv */
// Package for the triangle raster / depth test block.
// Types, codes and constants shared by rtdt_zdiv and triangle_raster_depth_test.
// No dependencies.
`default_nettype none

package rtdt_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic signed [14:0] DEPTH_FAR = 15'sd16383;
    localparam logic signed [14:0] DEPTH_MIN = -15'sd16384;

    // item kinds carried in s_tuser
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CCOLOR = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SETUP,
        ST_CHECK,
        ST_PIX,
        ST_ZMUL,
        ST_DIV,
        ST_RDZ,
        ST_CMP,
        ST_READ,
        ST_READW,
        ST_DONE
    } rtdt_state_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic signed [14:0] z;
    } zdiv_res_t;

endpackage

`default_nettype wire

/* rtl/core/rtdt_zdiv.sv */
// Depth divider: restoring division of the weighted depth sum by the area,
// one quotient bit per cycle, truncated toward zero and saturated to Q1.14.
// Depends on rtdt_pkg.
`default_nettype none

module rtdt_zdiv
    import rtdt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [45:0] num,
    input  wire logic signed [28:0] den,   // always >= 1 here
    output zdiv_res_t               res
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [42:0]        rem_reg, rem_next;
    logic [42:0]        dsh_reg, dsh_next;
    logic [14:0]        q_reg, q_next;
    logic               neg_reg, neg_next;
    logic signed [45:0] mag;
    logic               ge;

    assign mag = num[45] ? -num : num;
    assign ge  = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd15;
            rem_next  = mag[42:0];
            dsh_next  = {1'b0, den[27:0], 14'b0};
            q_next    = '0;
            neg_next  = num[45];
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[13:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    // top quotient bit set: magnitude >= 16384 * area, saturate
    always_comb
    begin
        res.done = done_reg;
        if (neg_reg)
        begin
            res.z = q_reg[14] ? DEPTH_MIN : -$signed(q_reg);
        end
        else
        begin
            res.z = q_reg[14] ? DEPTH_FAR : $signed(q_reg);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/triangle_raster_depth_test.sv */
// Triangle rasterizer with color and depth stores: top level, sequencer and
// stores. Depends on rtdt_pkg and rtdt_zdiv.
//
// Each word on s_* is one command (s_tuser: clear, draw, read) and produces
// exactly one result word on m_*. The block takes one command at a time.
// A clear sweeps both stores, one entry per cycle; the same sweep (writing
// color 0, depth far) runs after reset, before s_tready first rises. A read
// addresses the stores in ST_READ, takes the registered data in ST_READW and
// then returns it. A draw runs setup and cull check (nine products through
// the shared multiplier), then walks the clamped bounding box pixel by pixel.
// Each covered pixel adds the three depth products, the restoring divider and
// a depth read on the read port then a compare-write on the write port, and
// the walk moves on only after the compare. The walked box is at most
// (MAX_WIDTH-1)*(MAX_HEIGHT-1) pixels, 3969 at 64x64. A finished result
// sits in the output register while the next command is accepted.
`default_nettype none

module triangle_raster_depth_test
    import rtdt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    // command stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ax[12:0] ay[25:13] az[40:26] bx[53:41] by[66:54] bz[81:67]
    // cx[94:82] cy[107:95] cz[122:108] tri_color[146:123] pixel_index[158:147]
    input  wire logic [159:0] s_tdata,
    input  wire logic [1:0]   s_tuser,   // kind[1:0]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // read_color[23:0] read_depth[38:24] pixels_written[51:39] culled[52]
    output logic [55:0]       m_tdata
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(STORE_SIZE);

    // ---------------- state and registers ----------------
    rtdt_state_t state_reg, state_next;

    logic [6:0]  fw_reg, fh_reg;
    logic [23:0] cc_reg;

    logic signed [12:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [14:0] az_reg, bz_reg, cz_reg;
    logic [23:0]        col_reg;
    logic [11:0]        pix_reg;

    logic [3:0]         step_reg;
    logic signed [45:0] p_reg, acc_reg;
    logic signed [28:0] area_reg;
    logic signed [28:0] re0_reg, re1_reg, re2_reg;   // edges at row start
    logic signed [28:0] pe0_reg, pe1_reg, pe2_reg;   // edges at pixel
    logic signed [12:0] x_reg, y_reg;
    logic [AW-1:0]      rowbase_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic signed [14:0] z_reg;

    logic [23:0]        res_color_reg;
    logic signed [14:0] res_depth_reg;
    logic [12:0]        res_count_reg;
    logic               res_cull_reg;

    logic               out_valid_reg;
    logic [55:0]        out_data_reg;

    // stores
    logic [23:0]        color_mem [STORE_SIZE];
    logic [14:0]        depth_mem [STORE_SIZE];
    logic [23:0]        rd_color_reg;
    logic [14:0]        rd_depth_reg;

    // ---------------- combinational helpers ----------------
    logic               accept;
    logic signed [12:0] w_s, h_s;
    logic signed [12:0] minx, miny, maxx, maxy;
    logic signed [12:0] x0, y0, x1, y1;
    logic signed [13:0] d_bax, d_cay, d_bay, d_cax, d_cbx, d_cby, d_acx, d_acy;
    logic signed [29:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [45:0] prod;
    logic               covered;
    logic               last_x, last_y;
    logic [AW-1:0]      idx;
    logic               mem_we;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [23:0]        wr_color;
    logic [14:0]        wr_depth;
    logic               div_start;
    logic signed [45:0] div_num;
    logic               z_wins;
    logic               out_load;
    zdiv_res_t          zr;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // active frame size, saturated
    always_comb
    begin
        if (fw_reg == 7'd0)
            w_s = 13'sd1;
        else if (int'(fw_reg) > MAX_WIDTH)
            w_s = 13'(MAX_WIDTH);
        else
            w_s = 13'(fw_reg);
        if (fh_reg == 7'd0)
            h_s = 13'sd1;
        else if (int'(fh_reg) > MAX_HEIGHT)
            h_s = 13'(MAX_HEIGHT);
        else
            h_s = 13'(fh_reg);
    end

    // bounding box clamped to the frame
    always_comb
    begin
        minx = (ax_reg < bx_reg) ? ax_reg : bx_reg;
        minx = (minx < cx_reg) ? minx : cx_reg;
        miny = (ay_reg < by_reg) ? ay_reg : by_reg;
        miny = (miny < cy_reg) ? miny : cy_reg;
        maxx = (ax_reg > bx_reg) ? ax_reg : bx_reg;
        maxx = (maxx > cx_reg) ? maxx : cx_reg;
        maxy = (ay_reg > by_reg) ? ay_reg : by_reg;
        maxy = (maxy > cy_reg) ? maxy : cy_reg;
        x0 = (minx < 0) ? 13'sd0 : ((minx > w_s - 13'sd1) ? w_s - 13'sd1 : minx);
        y0 = (miny < 0) ? 13'sd0 : ((miny > h_s - 13'sd1) ? h_s - 13'sd1 : miny);
        x1 = (maxx < 0) ? 13'sd0 : ((maxx > w_s - 13'sd1) ? w_s - 13'sd1 : maxx);
        y1 = (maxy < 0) ? 13'sd0 : ((maxy > h_s - 13'sd1) ? h_s - 13'sd1 : maxy);
    end

    assign d_bax = 14'(bx_reg) - 14'(ax_reg);
    assign d_cay = 14'(cy_reg) - 14'(ay_reg);
    assign d_bay = 14'(by_reg) - 14'(ay_reg);
    assign d_cax = 14'(cx_reg) - 14'(ax_reg);
    assign d_cbx = 14'(cx_reg) - 14'(bx_reg);
    assign d_cby = 14'(cy_reg) - 14'(by_reg);
    assign d_acx = 14'(ax_reg) - 14'(cx_reg);
    assign d_acy = 14'(ay_reg) - 14'(cy_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                4'd0:    begin mul_a = 30'(d_bax); mul_b = 16'(d_cay); end
                4'd1:    begin mul_a = 30'(d_bay); mul_b = 16'(d_cax); end
                4'd2:    begin mul_a = 30'(d_cbx); mul_b = 16'(y0) - 16'(by_reg); end
                4'd3:    begin mul_a = 30'(d_cby); mul_b = 16'(x0) - 16'(bx_reg); end
                4'd4:    begin mul_a = 30'(d_acx); mul_b = 16'(y0) - 16'(cy_reg); end
                4'd5:    begin mul_a = 30'(d_acy); mul_b = 16'(x0) - 16'(cx_reg); end
                4'd6:    begin mul_a = 30'(d_bax); mul_b = 16'(y0) - 16'(ay_reg); end
                4'd7:    begin mul_a = 30'(d_bay); mul_b = 16'(x0) - 16'(ax_reg); end
                4'd8:    begin mul_a = 30'(w_s);   mul_b = 16'(h_s) - 16'sd1 - 16'(y0); end
                default: begin mul_a = '0;         mul_b = '0; end
            endcase
        end
        else if (state_reg == ST_ZMUL)
        begin
            case (step_reg)
                4'd0:    begin mul_a = 30'(pe0_reg); mul_b = 16'(az_reg); end
                4'd1:    begin mul_a = 30'(pe1_reg); mul_b = 16'(bz_reg); end
                4'd2:    begin mul_a = 30'(pe2_reg); mul_b = 16'(cz_reg); end
                default: begin mul_a = '0;           mul_b = '0; end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    assign covered = !pe0_reg[28] && !pe1_reg[28] && !pe2_reg[28];
    assign last_x  = (x_reg + 13'sd1) == x1;
    assign last_y  = (y_reg + 13'sd1) == y1;
    assign idx     = rowbase_reg + AW'($unsigned(x_reg));
    assign div_num = acc_reg + p_reg;
    assign z_wins  = z_reg < $signed(rd_depth_reg);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        wr_addr    = idx;
        wr_color   = col_reg;
        wr_depth   = z_reg;
        rd_addr    = idx;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_color = '0;
                wr_depth = DEPTH_FAR;
                if (clr_cnt_reg == AW'(STORE_SIZE - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_DRAW:  state_next = ST_SETUP;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_color = cc_reg;
                wr_depth = DEPTH_FAR;
                if (clr_cnt_reg == AW'(STORE_SIZE - 1))
                    state_next = ST_DONE;
            end
            ST_SETUP:
            begin
                if (step_reg == 4'd9)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (area_reg < 29'sd1 || x0 >= x1 || y0 >= y1)
                    state_next = ST_DONE;
                else
                    state_next = ST_PIX;
            end
            ST_PIX:
            begin
                if (covered)
                    state_next = ST_ZMUL;
                else if (last_x && last_y)
                    state_next = ST_DONE;
            end
            ST_ZMUL:
            begin
                if (step_reg == 4'd3)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (zr.done)
                    state_next = ST_RDZ;
            end
            ST_RDZ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                mem_we = z_wins;
                state_next = (last_x && last_y) ? ST_DONE : ST_PIX;
            end
            ST_READ:
            begin
                rd_addr    = AW'(pix_reg);
                state_next = ST_READW;
            end
            ST_READW:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    // control counters, config and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg        <= 7'd64;
            fh_reg        <= 7'd64;
            cc_reg        <= '0;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  fw_reg <= cfg_data[6:0];
                    CFG_HEIGHT: fh_reg <= cfg_data[6:0];
                    CFG_CCOLOR: cc_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (state_reg == ST_INIT || state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            else
                clr_cnt_reg <= '0;
            if (state_reg == ST_SETUP || state_reg == ST_ZMUL)
                step_reg <= (state_next == state_reg) ? step_reg + 4'd1 : 4'd0;
            else
                step_reg <= '0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        if (accept)
        begin
            ax_reg  <= $signed(s_tdata[12:0]);
            ay_reg  <= $signed(s_tdata[25:13]);
            az_reg  <= $signed(s_tdata[40:26]);
            bx_reg  <= $signed(s_tdata[53:41]);
            by_reg  <= $signed(s_tdata[66:54]);
            bz_reg  <= $signed(s_tdata[81:67]);
            cx_reg  <= $signed(s_tdata[94:82]);
            cy_reg  <= $signed(s_tdata[107:95]);
            cz_reg  <= $signed(s_tdata[122:108]);
            col_reg <= s_tdata[146:123];
            pix_reg <= s_tdata[158:147];
            res_color_reg <= '0;
            res_depth_reg <= '0;
            res_count_reg <= '0;
            res_cull_reg  <= 1'b0;
        end
        // setup: consume the product started one step earlier
        if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                4'd1:    acc_reg     <= p_reg;
                4'd2:    area_reg    <= 29'(acc_reg - p_reg);
                4'd3:    acc_reg     <= p_reg;
                4'd4:    re0_reg     <= 29'(acc_reg - p_reg);
                4'd5:    acc_reg     <= p_reg;
                4'd6:    re1_reg     <= 29'(acc_reg - p_reg);
                4'd7:    acc_reg     <= p_reg;
                4'd8:    re2_reg     <= 29'(acc_reg - p_reg);
                4'd9:    rowbase_reg <= AW'(p_reg);
                default: ;
            endcase
        end
        if (state_reg == ST_CHECK)
        begin
            if (area_reg < 29'sd1 || x0 >= x1 || y0 >= y1)
                res_cull_reg <= 1'b1;
            x_reg   <= x0;
            y_reg   <= y0;
            pe0_reg <= re0_reg;
            pe1_reg <= re1_reg;
            pe2_reg <= re2_reg;
        end
        if (state_reg == ST_ZMUL)
        begin
            if (step_reg == 4'd1)
                acc_reg <= p_reg;
            else if (step_reg == 4'd2)
                acc_reg <= acc_reg + p_reg;
        end
        if (state_reg == ST_DIV && zr.done)
            z_reg <= zr.z;
        if (state_reg == ST_CMP && z_wins)
            res_count_reg <= res_count_reg + 13'd1;
        // step to the next pixel of the box
        if ((state_reg == ST_PIX && !covered) || state_reg == ST_CMP)
        begin
            if (!last_x)
            begin
                x_reg   <= x_reg + 13'sd1;
                pe0_reg <= pe0_reg - 29'(d_cby);
                pe1_reg <= pe1_reg - 29'(d_acy);
                pe2_reg <= pe2_reg - 29'(d_bay);
            end
            else
            begin
                x_reg       <= x0;
                y_reg       <= y_reg + 13'sd1;
                re0_reg     <= re0_reg + 29'(d_cbx);
                re1_reg     <= re1_reg + 29'(d_acx);
                re2_reg     <= re2_reg + 29'(d_bax);
                pe0_reg     <= re0_reg + 29'(d_cbx);
                pe1_reg     <= re1_reg + 29'(d_acx);
                pe2_reg     <= re2_reg + 29'(d_bax);
                rowbase_reg <= rowbase_reg - AW'($unsigned(w_s));
            end
        end
        if (state_reg == ST_READW && 32'(pix_reg) < STORE_SIZE)
        begin
            res_color_reg <= rd_color_reg;
            res_depth_reg <= $signed(rd_depth_reg);
        end
        if (out_load)
        begin
            out_data_reg <= {3'b0, res_cull_reg, res_count_reg,
                             res_depth_reg, res_color_reg};
        end
    end

    // stores: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[wr_addr] <= wr_color;
            depth_mem[wr_addr] <= wr_depth;
        end
        rd_color_reg <= color_mem[rd_addr];
        rd_depth_reg <= depth_mem[rd_addr];
    end

    rtdt_zdiv u_zdiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (area_reg),
        .res   (zr)
    );

    // ---------------- checks ----------------
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_CMP))
        else $error("store written outside clear or depth test");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        zr.done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide wait");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second command taken back to back");

    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without finishing a command");

endmodule

`default_nettype wire
